[rtl/core/vdti_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vdti_pkg: shared types for the vertex dedup triangle indexer
// Vertex, result and queue-entry structs, fixed field widths.
// ----------------------------------------------------------------------------
package vdti_pkg;

    localparam int COORD_BITS = 32;
    localparam int IDX_BITS   = 10;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } vertex_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] vertex_index;
        logic                is_new;
        logic                overflow;
        logic                triangle_done;
        logic [IDX_BITS-1:0] corner_a;
        logic [IDX_BITS-1:0] corner_b;
        logic [IDX_BITS-1:0] corner_c;
    } result_t;

    typedef struct packed {
        logic    valid;
        vertex_t vertex;
    } queue_t;

endpackage
`default_nettype wire

[rtl/core/vdti_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vdti_front: command intake and vertex queue
// Takes a vertex transfer on start while not busy and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module vdti_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire vdti_pkg::vertex_t item,
    output logic                  busy,
    output vdti_pkg::queue_t      q,
    input  wire logic             pop
);
    import vdti_pkg::*;

    vertex_t    slot_reg [2];
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       push;

    assign busy     = (fill_reg == 2'd2);
    assign push     = start && !busy;
    assign q.valid  = (fill_reg != 2'd0);
    assign q.vertex = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> fill_reg != 2'd0)
        else $error("queue popped while empty");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0 || fill_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

[rtl/core/vdti_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vdti_back: table scan engine
// Scans the unique-vertex table one entry per cycle, appends on a miss
// unless full, tracks triangle corners and registers the result strobe.
// ----------------------------------------------------------------------------
module vdti_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vdti_pkg::queue_t q,
    output logic                  pop,
    output logic                  done,
    output vdti_pkg::result_t     result
);
    import vdti_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (IW > IDX_BITS) ? IW : IDX_BITS;
    localparam int KW = 3 * COORD_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    logic [KW-1:0]       mem [TABLE_DEPTH];
    logic [KW-1:0]       rdata_reg;

    logic                state_reg;
    logic                state_next;
    vertex_t             cur_reg;
    logic [CW-1:0]       rd_addr_reg;
    logic [CW-1:0]       rd_addr_next;
    logic [IW-1:0]       cmp_addr_reg;
    logic                pend_reg;
    logic                pend_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic [IDX_BITS-1:0] held_a_reg;
    logic [IDX_BITS-1:0] held_a_next;
    logic [IDX_BITS-1:0] held_b_reg;
    logic [IDX_BITS-1:0] held_b_next;
    logic                done_reg;
    result_t             result_reg;
    result_t             result_next;

    logic [KW-1:0]       key;
    logic                hit;
    logic                miss;
    logic                issue;
    logic                full;
    logic                wr_en;
    logic                finish;
    logic [IW-1:0]       idx;
    logic [XW-1:0]       idx_wide;
    logic [IDX_BITS-1:0] idx_out;

    assign key      = {cur_reg.coord_x, cur_reg.coord_y, cur_reg.coord_z};
    assign full     = (count_reg == CW'(TABLE_DEPTH));
    assign hit      = (state_reg == ST_SCAN) && pend_reg && (rdata_reg == key);
    assign miss     = (state_reg == ST_SCAN) && !pend_reg && (rd_addr_reg == count_reg);
    assign issue    = (state_reg == ST_SCAN) && !hit && (rd_addr_reg < count_reg);
    assign wr_en    = miss && !full;
    assign finish   = hit || miss;
    assign pop      = (state_reg == ST_IDLE) && q.valid;
    assign idx      = hit ? cmp_addr_reg : (full ? '0 : count_reg[IW-1:0]);
    assign idx_wide = XW'(idx);
    assign idx_out  = idx_wide[IDX_BITS-1:0];
    assign done     = done_reg;
    assign result   = result_reg;

    always_comb
    begin
        state_next   = state_reg;
        rd_addr_next = rd_addr_reg;
        pend_next    = 1'b0;
        count_next   = count_reg;
        phase_next   = phase_reg;
        held_a_next  = held_a_reg;
        held_b_next  = held_b_reg;
        result_next  = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next   = ST_SCAN;
                    rd_addr_next = '0;
                end
            end
            ST_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            count_next = count_reg + CW'(1);
        end

        if (finish)
        begin
            result_next.vertex_index  = idx_out;
            result_next.is_new        = wr_en;
            result_next.overflow      = miss && full;
            result_next.triangle_done = 1'b0;
            result_next.corner_a      = '0;
            result_next.corner_b      = '0;
            result_next.corner_c      = '0;
            case (phase_reg)
                PH_A:
                begin
                    held_a_next = idx_out;
                    phase_next  = PH_B;
                end
                PH_B:
                begin
                    held_b_next = idx_out;
                    phase_next  = PH_C;
                end
                default:
                begin
                    result_next.triangle_done = 1'b1;
                    result_next.corner_a      = held_a_reg;
                    result_next.corner_b      = held_b_reg;
                    result_next.corner_c      = idx_out;
                    phase_next                = PH_A;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_addr_reg <= '0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            phase_reg   <= PH_A;
            held_a_reg  <= '0;
            held_b_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_addr_reg <= rd_addr_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            held_a_reg  <= held_a_next;
            held_b_reg  <= held_b_next;
            done_reg    <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (pop)
        begin
            cur_reg <= q.vertex;
        end
        if (issue)
        begin
            cmp_addr_reg <= rd_addr_reg[IW-1:0];
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IW-1:0]] <= key;
        end
        if (issue)
        begin
            rdata_reg <= mem[rd_addr_reg[IW-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("unique count above table depth");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("corner phase out of range");

    a_new_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(result_reg.is_new && result_reg.overflow))
        else $error("result both new and overflow");

    a_corner_c: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.triangle_done) |->
            result_reg.corner_c == result_reg.vertex_index)
        else $error("third corner differs from vertex index");

    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == ST_SCAN)
        else $error("read pending outside scan");

endmodule
`default_nettype wire

[rtl/core/vertex_dedup_triangle_indexer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_dedup_triangle_indexer_unit: mesh vertex dedup and triangle indexer
// The scan reads the N stored unique vertices (N at most TABLE_DEPTH) and
//   ends at the first matching entry; a miss appends the vertex unless full.
// The vertex table has a single read port and is scanned one entry per cycle;
//   a two-entry queue takes starts while a scan runs.
// Reset: queue empty, unique count and corner phase zero; table not cleared.
// Results are a one-cycle done strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module vertex_dedup_triangle_indexer_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire vdti_pkg::vertex_t item,
    output logic                   busy,
    output logic                   done,
    output vdti_pkg::result_t      result
);
    import vdti_pkg::*;

    queue_t q;
    logic   pop;

    vdti_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .q     (q),
        .pop   (pop)
    );

    vdti_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q      (q),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule
`default_nettype wire
